// ===== rtl/servo_motion_trigger_fsm_core_macros.svh =====
// Assertion macros used by the checker file.
`ifndef SERVO_MOTION_TRIGGER_FSM_CORE_MACROS_SVH
`define SERVO_MOTION_TRIGGER_FSM_CORE_MACROS_SVH

// Checks a property on every rising edge of clk_i outside of reset.
`define SMTF_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("smtf assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define SMTF_ASSERT_NEXT(name, ante, cons) \
  `SMTF_ASSERT(name, (ante) |=> (cons))

`endif

// ===== rtl/smtf_pkg.sv =====
`default_nettype none

package smtf_pkg;

  localparam int POS_W     = 16;
  localparam int PULSE_W   = 12;
  localparam int MODE_W    = 2;
  localparam int CFG_IDX_W = 2;
  localparam int PHASE_W   = 16;
  localparam int STEP_W    = 15;
  localparam int PROD_W    = 28;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE_CH0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE_CH1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPAN     = 2'd2;

  localparam logic [PULSE_W-1:0] SPAN_RESET = 12'd1000;

  typedef enum logic [MODE_W-1:0] {
    MODE_ASTABLE  = 2'd0,
    MODE_BISTABLE = 2'd1,
    MODE_ONESHOT  = 2'd2,
    MODE_NONE     = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_ATOB  = 3'd1,
    ST_ATTOP = 3'd2,
    ST_BTOA  = 3'd3,
    ST_WAIT  = 3'd4
  } motion_e;

  typedef enum logic [2:0] {
    C_IDLE,
    C_CALC,
    C_SCALE,
    C_MULT,
    C_DONE
  } ctrl_e;

  typedef struct packed {
    motion_e              motion;
    logic                 up;
    logic [PHASE_W-1:0]   phase;
    logic [PULSE_W-1:0]   last_pulse;
  } chan_entry_t;

  typedef struct packed {
    motion_e            motion;
    logic               up;
    logic [PHASE_W-1:0] phase;
  } motion_res_t;

  localparam logic [STEP_W-1:0] STEP_TABLE [17] = '{
    15'd437,   15'd583,   15'd749,   15'd1049,
    15'd1311,  15'd1748,  15'd2185,  15'd2621,
    15'd3277,  15'd4369,  15'd5243,  15'd6554,
    15'd8738,  15'd10923, 15'd13107, 15'd16384,
    15'd26214
  };

  // Table entry selected by the top nibble, plus a linear share of the gap
  // to the next entry selected by the second nibble.
  function automatic logic [STEP_W-1:0] step_size(logic [POS_W-1:0] tt);
    logic [4:0]        idx;
    logic [STEP_W-1:0] gap;
    logic [STEP_W-1:0] part;
    idx  = {1'b0, tt[15:12]};
    gap  = STEP_TABLE[idx + 5'd1] - STEP_TABLE[idx];
    part = STEP_W'(gap[STEP_W-1:4]) * STEP_W'(tt[11:8]);
    return STEP_TABLE[idx] + part;
  endfunction

  function automatic motion_res_t motion_next(mode_e mode, motion_e st, logic up,
                                              logic [PHASE_W-1:0] ph, logic trig,
                                              logic [STEP_W-1:0] step);
    motion_res_t        r;
    logic [PHASE_W:0]   pu;
    logic [PHASE_W:0]   pd;
    logic               ovf;
    logic               unf;
    logic               clamp_cur;
    logic [PHASE_W-1:0] phu;
    logic [PHASE_W-1:0] phd;
    logic [PHASE_W-1:0] ph_cur;
    pu  = {1'b0, ph} + {2'b00, step};
    pd  = {1'b0, ph} - {2'b00, step};
    ovf = pu[PHASE_W];
    unf = pd[PHASE_W];
    phu = ovf ? '1 : pu[PHASE_W-1:0];
    phd = unf ? '0 : pd[PHASE_W-1:0];
    clamp_cur = up ? ovf : unf;
    ph_cur    = up ? phu : phd;
    r.motion = st;
    r.up     = up;
    r.phase  = ph;
    unique case (mode)
      MODE_ASTABLE: begin
        unique case (st)
          ST_IDLE: begin
            if (trig) begin
              r.motion = ST_ATOB;
              r.up     = 1'b1;
            end
          end
          ST_ATOB: begin
            if (!trig) begin
              r.motion = ST_IDLE;
              r.up     = 1'b0;
            end else begin
              r.phase = ph_cur;
              if (clamp_cur) begin
                r.motion = ST_BTOA;
                r.up     = 1'b0;
              end
            end
          end
          ST_ATTOP: begin
            r.motion = ST_BTOA;
            r.up     = 1'b0;
          end
          ST_BTOA: begin
            if (!trig) begin
              r.motion = ST_IDLE;
              r.up     = 1'b0;
            end else begin
              r.phase = ph_cur;
              if (clamp_cur) begin
                r.motion = ST_ATOB;
                r.up     = 1'b1;
              end
            end
          end
          default: ;
        endcase
      end
      MODE_BISTABLE: begin
        unique case (st)
          ST_IDLE: begin
            if (trig) begin
              r.motion = ST_ATOB;
              r.up     = 1'b1;
            end
          end
          ST_ATOB: begin
            // A release turns the channel around and it steps down at once;
            // a clamp at either end still lands in the top state.
            if (!trig) begin
              r.up     = 1'b0;
              r.phase  = phd;
              r.motion = unf ? ST_ATTOP : ST_BTOA;
            end else begin
              r.phase = ph_cur;
              if (clamp_cur) r.motion = ST_ATTOP;
            end
          end
          ST_ATTOP: begin
            if (!trig) begin
              r.motion = ST_BTOA;
              r.up     = 1'b0;
            end
          end
          ST_BTOA: begin
            if (trig) begin
              r.up     = 1'b1;
              r.phase  = phu;
              r.motion = ovf ? ST_IDLE : ST_ATOB;
            end else begin
              r.phase = ph_cur;
              if (clamp_cur) r.motion = ST_IDLE;
            end
          end
          default: ;
        endcase
      end
      MODE_ONESHOT: begin
        unique case (st)
          ST_IDLE: begin
            if (trig) begin
              r.motion = ST_ATOB;
              r.up     = 1'b1;
            end
          end
          ST_ATOB: begin
            r.phase = ph_cur;
            if (clamp_cur) begin
              r.motion = ST_BTOA;
              r.up     = 1'b0;
            end
          end
          ST_ATTOP: begin
            r.motion = ST_BTOA;
            r.up     = 1'b0;
          end
          ST_BTOA: begin
            r.phase = ph_cur;
            if (clamp_cur) r.motion = ST_WAIT;
          end
          ST_WAIT: begin
            if (!trig) r.motion = ST_IDLE;
          end
          default: ;
        endcase
      end
      MODE_NONE: ;
      default: ;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/smtf_if.sv =====
`default_nettype none

interface smtf_in_if;
  import smtf_pkg::*;
  logic               valid;
  logic               ready;
  logic               channel;
  logic               trigger_level;
  logic [POS_W-1:0]   position_a;
  logic [POS_W-1:0]   position_b;
  logic [POS_W-1:0]   travel_time;

  modport source (output valid, channel, trigger_level, position_a, position_b,
                  travel_time, input ready);
  modport sink (input valid, channel, trigger_level, position_a, position_b,
                travel_time, output ready);
endinterface

interface smtf_out_if;
  import smtf_pkg::*;
  logic               valid;
  logic               ready;
  logic [PULSE_W-1:0] pulse_us;

  modport source (output valid, pulse_us, input ready);
  modport sink (input valid, pulse_us, output ready);
endinterface

interface smtf_cfg_if;
  import smtf_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [PULSE_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/smtf_div65535.sv =====
`default_nettype none

module smtf_div65535 (
  input  wire logic [smtf_pkg::PROD_W-1:0] num_i,
  output logic [smtf_pkg::PULSE_W-1:0]     quo_o
);
  import smtf_pkg::*;

  logic [PULSE_W-1:0] q0;
  logic [16:0]        rem;

  // num = q0 * 65536 + lo = q0 * 65535 + (lo + q0); the remainder term stays
  // below twice the divisor, so one correction step finishes the quotient.
  always_comb begin
    q0    = num_i[PROD_W-1:16];
    rem   = {1'b0, num_i[15:0]} + {5'b0, q0};
    quo_o = (rem >= 17'd65535) ? q0 + 12'd1 : q0;
  end

endmodule

`default_nettype wire

// ===== rtl/servo_motion_trigger_fsm_core.sv =====
// Servo motion trigger core.
// Input channel in_i carries one tick per transaction: the servo channel, the
// trigger level, the two end-position readings and the travel-time reading.
// Output channel out_o returns one pulse_us per tick, in tick order.
// Configuration channel cfg_i writes the two channel modes (index 0 and 1)
// and the pulse span (index 2); it is always ready. The user must write it
// only while the core has no tick in flight; the core does not enforce this.
// Per-channel motion state, direction, phasor and last pulse live in a small
// state memory with a registered read. A tick is read at acceptance, then
// passes through four steps (state update, end-position scaling, phasor
// multiply, final divide and write-back); the result is registered on out_o
// as the core leaves its last step, and the next tick is taken in the
// following cycle; the core works one tick at a time. The two multiply-divide
// rounds are chained through one pipeline of registers.
// While a result waits on out_o the core still accepts and works a new tick,
// holding it in its last step until the output register frees up.
// Reset puts every channel at idle with a zero phasor and zero last pulse,
// both modes at none and the span at 1000 us; no clearing pass is needed.
`default_nettype none

module servo_motion_trigger_fsm_core #(
  parameter int NUM_CHANNELS = 2
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  smtf_cfg_if.sink    cfg_i,
  smtf_in_if.sink     in_i,
  smtf_out_if.source  out_o
);
  import smtf_pkg::*;

  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [1:0] NumCh = 2'(NUM_CHANNELS);

  ctrl_e ctrl_q, ctrl_d;

  mode_e              mode_q [2];
  logic [PULSE_W-1:0] span_q;

  chan_entry_t              mem_q [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0]  vld_q;
  chan_entry_t              rd_q;
  logic                     rd_vld_q;

  logic               ch_q;
  logic               trig_q;
  logic [POS_W-1:0]   pos_a_q;
  logic [POS_W-1:0]   pos_b_q;
  logic [STEP_W-1:0]  step_q;

  chan_entry_t        ent_q;
  logic               none_q;
  logic               oor_q;
  logic               neg_q;
  logic [PROD_W-1:0]  prod_r_q;
  logic [PROD_W-1:0]  prod_o_q;
  logic [PULSE_W-1:0] range_q;
  logic [PULSE_W-1:0] offset_q;
  logic [PROD_W-1:0]  pprod_q;

  logic               out_valid_q;
  logic [PULSE_W-1:0] out_pulse_q;

  logic               in_acc;
  logic               in_rng;
  logic               out_free;
  logic               load_out;
  logic               wr_en;
  logic [CH_W-1:0]    in_addr;
  logic [CH_W-1:0]    wr_addr;
  chan_entry_t        cur_ent;
  motion_res_t        mres;
  mode_e              mode_cur;
  logic [POS_W:0]     diff;
  logic [POS_W:0]     diff_abs;
  logic [PROD_W-1:0]  prod_r_d;
  logic [PROD_W-1:0]  prod_o_d;
  logic [PULSE_W-1:0] range_d;
  logic [PULSE_W-1:0] offset_d;
  logic [PULSE_W-1:0] quo_d;
  logic [PULSE_W-1:0] pulse_d;
  chan_entry_t        wr_data;

  // Control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= C_IDLE;
    end else begin
      ctrl_q <= ctrl_d;
    end
  end

  always_comb begin
    ctrl_d     = ctrl_q;
    in_i.ready = 1'b0;
    load_out   = 1'b0;
    unique case (ctrl_q)
      C_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) ctrl_d = C_CALC;
      end
      C_CALC:  ctrl_d = C_SCALE;
      C_SCALE: ctrl_d = C_MULT;
      C_MULT:  ctrl_d = C_DONE;
      C_DONE: begin
        if (out_free) begin
          load_out = 1'b1;
          ctrl_d   = C_IDLE;
        end
      end
      default: ctrl_d = C_IDLE;
    endcase
  end

  assign in_acc   = in_i.valid && in_i.ready;
  assign in_rng   = ({1'b0, in_i.channel} < NumCh);
  assign in_addr  = CH_W'(in_i.channel);
  assign out_free = !out_valid_q || out_o.ready;

  // Configuration registers.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q[0] <= MODE_NONE;
      mode_q[1] <= MODE_NONE;
      span_q    <= SPAN_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_MODE_CH0: mode_q[0] <= mode_e'(cfg_i.data[MODE_W-1:0]);
        CFG_MODE_CH1: mode_q[1] <= mode_e'(cfg_i.data[MODE_W-1:0]);
        CFG_SPAN:     span_q    <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // State memory. Only one tick is in flight, so its write-back always lands
  // before the next read and no forwarding is needed.
  assign wr_en   = load_out && !oor_q;
  assign wr_addr = CH_W'(ch_q);

  always_comb begin
    wr_data            = ent_q;
    wr_data.last_pulse = pulse_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    if (in_acc && in_rng) rd_q <= mem_q[in_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en) vld_q[wr_addr] <= 1'b1;
      if (in_acc) rd_vld_q <= in_rng ? vld_q[in_addr] : 1'b0;
    end
  end

  // Tick capture.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ch_q    <= in_i.channel;
      trig_q  <= in_i.trigger_level;
      pos_a_q <= in_i.position_a;
      pos_b_q <= in_i.position_b;
      step_q  <= step_size(in_i.travel_time);
    end
  end

  // State update and first products.
  always_comb begin
    if (rd_vld_q) begin
      cur_ent = rd_q;
    end else begin
      cur_ent.motion     = ST_IDLE;
      cur_ent.up         = 1'b0;
      cur_ent.phase      = '0;
      cur_ent.last_pulse = '0;
    end
    mode_cur = mode_q[ch_q];
    mres     = motion_next(mode_cur, cur_ent.motion, cur_ent.up, cur_ent.phase,
                           trig_q, step_q);
    diff     = {1'b0, pos_b_q} - {1'b0, pos_a_q};
    diff_abs = diff[POS_W] ? ({(POS_W+1){1'b0}} - diff) : diff;
    prod_r_d = PROD_W'(diff_abs[POS_W-1:0]) * PROD_W'(span_q);
    prod_o_d = PROD_W'(pos_a_q) * PROD_W'(span_q);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_q == C_CALC) begin
      ent_q.motion     <= mres.motion;
      ent_q.up         <= mres.up;
      ent_q.phase      <= mres.phase;
      ent_q.last_pulse <= cur_ent.last_pulse;
      none_q           <= (mode_cur == MODE_NONE);
      oor_q            <= !({1'b0, ch_q} < NumCh);
      neg_q            <= diff[POS_W];
      prod_r_q         <= prod_r_d;
      prod_o_q         <= prod_o_d;
    end
  end

  // Scaling: range and offset, then the phasor product, then the final
  // divide. Negative ranges are carried as magnitude and sign so that each
  // quotient truncates toward zero.
  smtf_div65535 u_div_range (
    .num_i (prod_r_q),
    .quo_o (range_d)
  );

  smtf_div65535 u_div_offset (
    .num_i (prod_o_q),
    .quo_o (offset_d)
  );

  smtf_div65535 u_div_pulse (
    .num_i (pprod_q),
    .quo_o (quo_d)
  );

  always_ff @(posedge clk_i) begin
    if (ctrl_q == C_SCALE) begin
      range_q  <= range_d;
      offset_q <= offset_d;
    end
    if (ctrl_q == C_MULT) begin
      pprod_q <= PROD_W'(ent_q.phase) * PROD_W'(range_q);
    end
  end

  always_comb begin
    if (oor_q) begin
      pulse_d = '0;
    end else if (none_q) begin
      pulse_d = ent_q.last_pulse;
    end else if (neg_q) begin
      pulse_d = offset_q - quo_d;
    end else begin
      pulse_d = offset_q + quo_d;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) out_pulse_q <= pulse_d;
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.pulse_us = out_pulse_q;

endmodule

`default_nettype wire

// ===== rtl/smtf_checker.sv =====
`default_nettype none
`include "servo_motion_trigger_fsm_core_macros.svh"

module smtf_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid_i,
  input wire logic                        in_ready_i,
  input wire logic                        out_valid_i,
  input wire logic                        out_ready_i,
  input wire logic [smtf_pkg::PULSE_W-1:0] pulse_us_i
);
  import smtf_pkg::*;

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  // A held result must not change while the receiver stalls.
  `SMTF_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(pulse_us_i))

  // One tick at a time: the core stays busy while a tick is worked.
  `SMTF_ASSERT_NEXT(a_busy_after_acc, in_acc, !in_ready_i ##1 !in_ready_i ##1 !in_ready_i)

  // A fresh result appears exactly when the core returns to taking ticks.
  `SMTF_ASSERT(a_result_frees_input, $rose(out_valid_i) |-> in_ready_i)

  // The core only goes busy because it took a tick.
  `SMTF_ASSERT(a_busy_needs_acc, $fell(in_ready_i) |-> $past(in_acc))

endmodule

bind servo_motion_trigger_fsm_core smtf_checker u_smtf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .pulse_us_i  (out_o.pulse_us)
);

`default_nettype wire
